/* src/scd_pkg.sv */
// shared types and codes of the job dependency scheduler
package scd_pkg;

   localparam int ID_W       = 32;
   localparam int HND_W      = 64;
   localparam int TL_W       = 64;
   localparam int CNT_W      = 3;
   localparam int FIELD_DEPS = 4;

   typedef enum logic [1:0] {
      OP_SUBMIT = 2'd0,
      OP_EVENT  = 2'd1,
      OP_UPDATE = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   localparam logic [2:0] KIND_SUBMIT   = 3'd0;
   localparam logic [2:0] KIND_DISPATCH = 3'd1;
   localparam logic [2:0] KIND_QUERY    = 3'd2;
   localparam logic [2:0] KIND_ACK      = 3'd3;
   localparam logic [2:0] KIND_IDLE     = 3'd4;

   localparam logic [1:0] ST_PENDING   = 2'd0;
   localparam logic [1:0] ST_SUBMITTED = 2'd1;
   localparam logic [1:0] ST_COMPLETED = 2'd2;
   localparam logic [1:0] ST_FAILED    = 2'd3;

   typedef struct packed {
      opcode_type                           opcode;
      logic [ID_W-1:0]                      target_id;
      logic                                 failed_flag;
      logic [HND_W-1:0]                     command_handle;
      logic                                 wait_graphics;
      logic [CNT_W-1:0]                     dep_count;
      logic [FIELD_DEPS-1:0][ID_W-1:0]      dep_ids;
   } cmd_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [ID_W-1:0]  id;
      logic [TL_W-1:0]  timeline;
      logic [HND_W-1:0] handle;
      logic             wait_flag;
      logic             done;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUB,
      S_DEPW,
      S_EVT,
      S_QRY,
      S_REPLY,
      U_SLOT,
      U_RD,
      U_CHK,
      U_DISP,
      U_END,
      F_SLOT,
      F_RD,
      F_CHK,
      F_FREE
   } state_type;

endpackage

/* src/scd_front.sv */
// front end: unpacks request transactions and queues decoded commands
module scd_front #(
   parameter int MAX_DEPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [239:0]           req_tdata,
   input  logic [1:0]             req_tuser,
   output logic                   cmd_valid,
   output scd_pkg::cmd_type       cmd_q,
   input  logic                   cmd_pop
);

   localparam int DEPS = (MAX_DEPS < 4) ? MAX_DEPS : 4;

   scd_pkg::cmd_type dec;
   scd_pkg::cmd_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   logic [7:0]       raw_cnt;

   // decode and clamp the dependency count
   always_comb begin
      raw_cnt            = req_tdata[105:98];
      dec.opcode         = scd_pkg::opcode_type'(req_tuser);
      dec.target_id      = req_tdata[31:0];
      dec.failed_flag    = req_tdata[32];
      dec.command_handle = req_tdata[96:33];
      dec.wait_graphics  = req_tdata[97];
      dec.dep_count      = (raw_cnt > 8'(DEPS)) ? 3'(DEPS) : raw_cnt[2:0];
      dec.dep_ids[0]     = req_tdata[137:106];
      dec.dep_ids[1]     = req_tdata[169:138];
      dec.dep_ids[2]     = req_tdata[201:170];
      dec.dep_ids[3]     = req_tdata[233:202];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd_q      = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      unique case ({push, cmd_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule

/* src/scd_engine.sv */
// back end: slot table, dependency walk, dispatch and output register
module scd_engine #(
   parameter int JOB_SLOTS = 16,
   parameter int MAX_DEPS  = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enabled,
   input  logic             cmd_valid,
   input  scd_pkg::cmd_type cmd_q,
   output logic             cmd_pop,
   input  logic             rsp_tready,
   output logic             rsp_valid,
   output scd_pkg::rsp_type rsp_data
);

   localparam int DEPS = (MAX_DEPS < 4) ? MAX_DEPS : 4;
   localparam int SW   = $clog2(JOB_SLOTS);
   localparam int DW   = (DEPS > 1) ? $clog2(DEPS) : 1;
   localparam int CW   = SW + 1;

   scd_pkg::state_type state_ff, state_in;
   scd_pkg::cmd_type   cmd_ff, cmd_in;

   logic [CW-1:0]            slot_ff, slot_in;
   logic [DW-1:0]            dep_ff, dep_in;
   logic [SW-1:0]            sub_slot_ff, sub_slot_in;
   logic [JOB_SLOTS-1:0]     active_ff, active_in;
   logic [JOB_SLOTS-1:0]     named_ff, named_in;
   logic [1:0]               status_ff [JOB_SLOTS];
   logic [1:0]               status_in [JOB_SLOTS];
   logic [31:0]              jid_ff [JOB_SLOTS];
   logic [31:0]              jid_in [JOB_SLOTS];
   logic                     wait_ff [JOB_SLOTS];
   logic                     wait_in [JOB_SLOTS];
   logic [2:0]               dcnt_ff [JOB_SLOTS];
   logic [2:0]               dcnt_in [JOB_SLOTS];
   logic [31:0]              next_id_ff, next_id_in;
   logic [63:0]              tl_ff, tl_in;
   logic                     hold_valid_ff, hold_valid_in;
   scd_pkg::rsp_type         hold_ff, hold_in;
   scd_pkg::rsp_type         reply_ff, reply_in;
   scd_pkg::rsp_type         out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic [63:0]              hnd_mem [JOB_SLOTS];
   logic [31:0]              dep_mem [JOB_SLOTS][DEPS];
   logic [63:0]              hnd_rd_ff;
   logic [31:0]              dep_rd_ff;
   logic                     hnd_we, dep_we;

   logic [SW-1:0]            cur;
   logic                     slot_end;
   logic                     cur_pending;
   logic                     dep_last;
   logic                     out_free;
   logic                     out_load;
   scd_pkg::rsp_type         out_data;
   logic [31:0]              cam_key;
   logic [JOB_SLOTS-1:0]     cam_match;
   logic                     cam_hit;
   logic [SW-1:0]            cam_idx;
   logic [1:0]               hit_status;
   logic                     key_done;
   logic                     free_any;
   logic [SW-1:0]            free_idx;
   logic [31:0]              nid_inc;

   assign cur         = slot_ff[SW-1:0];
   assign slot_end    = (slot_ff == CW'(JOB_SLOTS));
   assign cur_pending = active_ff[cur] && (status_ff[cur] == scd_pkg::ST_PENDING);
   assign dep_last    = ((3'(dep_ff) + 3'd1) == dcnt_ff[cur]);
   assign out_free    = !out_valid_ff || rsp_tready;
   assign nid_inc     = next_id_ff + 32'd1;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_ff;

   // id lookup over all slots, lowest match wins
   always_comb begin
      cam_key = ((state_ff == scd_pkg::U_CHK) || (state_ff == scd_pkg::F_CHK)) ?
                dep_rd_ff : cmd_ff.target_id;
      for (int k = 0; k < JOB_SLOTS; k++) begin
         cam_match[k] = active_ff[k] && (jid_ff[k] == cam_key);
      end
      cam_hit  = |cam_match;
      cam_idx  = '0;
      free_any = ~&active_ff;
      free_idx = '0;
      for (int k = JOB_SLOTS - 1; k >= 0; k--) begin
         if (cam_match[k]) begin
            cam_idx = SW'(k);
         end
         if (!active_ff[k]) begin
            free_idx = SW'(k);
         end
      end
      hit_status = status_ff[cam_idx];
      key_done   = (cam_key == 32'd0) || !cam_hit ||
                   (hit_status == scd_pkg::ST_COMPLETED) ||
                   (hit_status == scd_pkg::ST_FAILED);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_q.opcode)
                  scd_pkg::OP_SUBMIT: state_in = scd_pkg::S_SUB;
                  scd_pkg::OP_EVENT:  state_in = scd_pkg::S_EVT;
                  scd_pkg::OP_UPDATE: state_in = scd_pkg::U_SLOT;
                  scd_pkg::OP_QUERY:  state_in = scd_pkg::S_QRY;
                  default:            state_in = scd_pkg::S_IDLE;
               endcase
            end
         end
         scd_pkg::S_SUB: begin
            if (enabled && free_any && (cmd_ff.dep_count != 3'd0)) begin
               state_in = scd_pkg::S_DEPW;
            end else begin
               state_in = scd_pkg::S_REPLY;
            end
         end
         scd_pkg::S_DEPW: begin
            if ((3'(dep_ff) + 3'd1) == cmd_ff.dep_count) begin
               state_in = scd_pkg::S_REPLY;
            end
         end
         scd_pkg::S_EVT:   state_in = scd_pkg::S_REPLY;
         scd_pkg::S_QRY:   state_in = scd_pkg::S_REPLY;
         scd_pkg::S_REPLY: begin
            if (out_free) begin
               state_in = scd_pkg::S_IDLE;
            end
         end
         scd_pkg::U_SLOT: begin
            if (slot_end) begin
               state_in = scd_pkg::U_END;
            end else if (cur_pending) begin
               state_in = (dcnt_ff[cur] == 3'd0) ? scd_pkg::U_DISP : scd_pkg::U_RD;
            end
         end
         scd_pkg::U_RD: state_in = scd_pkg::U_CHK;
         scd_pkg::U_CHK: begin
            if (!key_done) begin
               state_in = scd_pkg::U_SLOT;
            end else if (dep_last) begin
               state_in = scd_pkg::U_DISP;
            end else begin
               state_in = scd_pkg::U_RD;
            end
         end
         scd_pkg::U_DISP: begin
            if (!hold_valid_ff || out_free) begin
               state_in = scd_pkg::U_SLOT;
            end
         end
         scd_pkg::U_END: begin
            if (out_free) begin
               state_in = scd_pkg::F_SLOT;
            end
         end
         scd_pkg::F_SLOT: begin
            if (slot_end) begin
               state_in = scd_pkg::F_FREE;
            end else if (cur_pending && (dcnt_ff[cur] != 3'd0)) begin
               state_in = scd_pkg::F_RD;
            end
         end
         scd_pkg::F_RD:   state_in = scd_pkg::F_CHK;
         scd_pkg::F_CHK:  state_in = dep_last ? scd_pkg::F_SLOT : scd_pkg::F_RD;
         scd_pkg::F_FREE: state_in = scd_pkg::S_IDLE;
         default:         state_in = scd_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop       = 1'b0;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      dep_in        = dep_ff;
      sub_slot_in   = sub_slot_ff;
      active_in     = active_ff;
      named_in      = named_ff;
      status_in     = status_ff;
      jid_in        = jid_ff;
      wait_in       = wait_ff;
      dcnt_in       = dcnt_ff;
      next_id_in    = next_id_ff;
      tl_in         = tl_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      reply_in      = reply_ff;
      hnd_we        = 1'b0;
      dep_we        = 1'b0;
      out_load      = 1'b0;
      out_data      = '0;
      unique case (state_ff)
         scd_pkg::S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd_q;
               slot_in       = '0;
               dep_in        = '0;
               hold_valid_in = 1'b0;
               named_in      = '0;
            end
         end
         scd_pkg::S_SUB: begin
            reply_in      = '0;
            reply_in.kind = scd_pkg::KIND_SUBMIT;
            if (enabled && free_any) begin
               active_in[free_idx] = 1'b1;
               status_in[free_idx] = scd_pkg::ST_PENDING;
               jid_in[free_idx]    = next_id_ff;
               wait_in[free_idx]   = cmd_ff.wait_graphics;
               dcnt_in[free_idx]   = cmd_ff.dep_count;
               hnd_we              = 1'b1;
               sub_slot_in         = free_idx;
               reply_in.id         = next_id_ff;
               // the id counter skips zero on wrap
               next_id_in          = (nid_inc == 32'd0) ? 32'd1 : nid_inc;
            end
         end
         scd_pkg::S_DEPW: begin
            dep_we = 1'b1;
            dep_in = dep_ff + DW'(1);
         end
         scd_pkg::S_EVT: begin
            if (cam_hit && (hit_status == scd_pkg::ST_SUBMITTED)) begin
               status_in[cam_idx] = cmd_ff.failed_flag ? scd_pkg::ST_FAILED :
                                                         scd_pkg::ST_COMPLETED;
            end
            reply_in      = '0;
            reply_in.kind = scd_pkg::KIND_ACK;
            reply_in.id   = cmd_ff.target_id;
         end
         scd_pkg::S_QRY: begin
            reply_in      = '0;
            reply_in.kind = scd_pkg::KIND_QUERY;
            reply_in.id   = cmd_ff.target_id;
            reply_in.done = key_done;
         end
         scd_pkg::S_REPLY: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_data      = reply_ff;
               out_data.last = 1'b1;
            end
         end
         scd_pkg::U_SLOT: begin
            if (!slot_end) begin
               if (cur_pending) begin
                  dep_in = '0;
               end else begin
                  slot_in = slot_ff + CW'(1);
               end
            end
         end
         scd_pkg::U_RD: begin
         end
         scd_pkg::U_CHK: begin
            if (!key_done) begin
               slot_in = slot_ff + CW'(1);
            end else if (!dep_last) begin
               dep_in = dep_ff + DW'(1);
            end
         end
         scd_pkg::U_DISP: begin
            if (!hold_valid_ff || out_free) begin
               // previous dispatch goes out now, this one is held
               if (hold_valid_ff) begin
                  out_load      = 1'b1;
                  out_data      = hold_ff;
                  out_data.last = 1'b0;
               end
               hold_valid_in     = 1'b1;
               hold_in           = '0;
               hold_in.kind      = scd_pkg::KIND_DISPATCH;
               hold_in.id        = jid_ff[cur];
               hold_in.timeline  = tl_ff + 64'd1;
               hold_in.handle    = hnd_rd_ff;
               hold_in.wait_flag = wait_ff[cur];
               tl_in             = tl_ff + 64'd1;
               status_in[cur]    = scd_pkg::ST_SUBMITTED;
               slot_in           = slot_ff + CW'(1);
            end
         end
         scd_pkg::U_END: begin
            if (out_free) begin
               out_load = 1'b1;
               if (hold_valid_ff) begin
                  out_data = hold_ff;
               end else begin
                  out_data.kind = scd_pkg::KIND_IDLE;
               end
               out_data.last = 1'b1;
               hold_valid_in = 1'b0;
               slot_in       = '0;
               named_in      = '0;
            end
         end
         scd_pkg::F_SLOT: begin
            if (!slot_end) begin
               if (cur_pending && (dcnt_ff[cur] != 3'd0)) begin
                  dep_in = '0;
               end else begin
                  slot_in = slot_ff + CW'(1);
               end
            end
         end
         scd_pkg::F_RD: begin
         end
         scd_pkg::F_CHK: begin
            named_in = named_ff | cam_match;
            if (dep_last) begin
               slot_in = slot_ff + CW'(1);
            end else begin
               dep_in = dep_ff + DW'(1);
            end
         end
         scd_pkg::F_FREE: begin
            for (int k = 0; k < JOB_SLOTS; k++) begin
               if (active_ff[k] && status_ff[k][1] && !named_ff[k]) begin
                  active_in[k] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
         out_in       = out_data;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
         out_in       = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scd_pkg::S_IDLE;
         slot_ff       <= '0;
         dep_ff        <= '0;
         active_ff     <= '0;
         next_id_ff    <= 32'd1;
         tl_ff         <= 64'd0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         dep_ff        <= dep_in;
         active_ff     <= active_in;
         next_id_ff    <= next_id_in;
         tl_ff         <= tl_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sub_slot_ff <= sub_slot_in;
      named_ff    <= named_in;
      status_ff   <= status_in;
      jid_ff      <= jid_in;
      wait_ff     <= wait_in;
      dcnt_ff     <= dcnt_in;
      hold_ff     <= hold_in;
      reply_ff    <= reply_in;
      out_ff      <= out_in;
   end

   // handle and dependency stores, registered read at the walk position
   always_ff @(posedge clock) begin
      if (hnd_we) begin
         hnd_mem[free_idx] <= cmd_ff.command_handle;
      end
      if (dep_we) begin
         dep_mem[sub_slot_ff][dep_ff] <= cmd_ff.dep_ids[2'(dep_ff)];
      end
      hnd_rd_ff <= hnd_mem[cur];
      dep_rd_ff <= dep_mem[cur][dep_ff];
   end

endmodule

/* src/job_dependency_scheduler.sv */
// top level of the job dependency scheduler
//
//  channel | dir | handshake             | payload
//  req_    | in  | req_tvalid/req_tready | tdata command fields, tuser opcode
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata result fields, tuser kind, tlast
//  csr_    | in  | csr_we                | csr_wdata enable bit
//
// submit steps through S_SUB, an S_DEPW step for each stored dependency id and
// S_REPLY; event and query go through S_EVT or S_QRY and then S_REPLY; update
// pass walks the slots in two sweeps plus a U_DISP step for each dispatch,
// paced by the single id lookup unit and the registered dependency store read
// reset is synchronous; a 2-entry command queue decouples req_ from the engine
// a stalled rsp_ holds the engine in place, the queue takes commands until full
module job_dependency_scheduler #(
   parameter int JOB_SLOTS = 16,
   parameter int MAX_DEPS  = 4
) (
   input  logic         clock,
   input  logic         reset,
   // target_id, failed_flag, command_handle, wait_graphics, dep_count,
   // dep_id_0, dep_id_1, dep_id_2, dep_id_3, zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [239:0] req_tdata,
   input  logic [1:0]   req_tuser,   // opcode
   // result_id, timeline_value, dispatch_handle, dispatch_wait, is_done,
   // zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // result_kind
   output logic         rsp_tlast,   // last
   input  logic         csr_we,
   input  logic         csr_wdata    // enabled
);

   logic             enabled_ff, enabled_in;
   logic             cmd_valid;
   logic             cmd_pop;
   scd_pkg::cmd_type cmd_q;
   scd_pkg::rsp_type rsp_data;

   // enable register, no read-back
   assign enabled_in = csr_we ? csr_wdata : enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   // front end decodes and queues commands
   scd_front #(
      .MAX_DEPS (MAX_DEPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_q      (cmd_q),
      .cmd_pop    (cmd_pop)
   );

   // engine owns the slot table and the result register
   scd_engine #(
      .JOB_SLOTS (JOB_SLOTS),
      .MAX_DEPS  (MAX_DEPS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .enabled    (enabled_ff),
      .cmd_valid  (cmd_valid),
      .cmd_q      (cmd_q),
      .cmd_pop    (cmd_pop),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_data)
   );

   // result transaction packing
   assign rsp_tdata = {6'd0, rsp_data.done, rsp_data.wait_flag, rsp_data.handle,
                       rsp_data.timeline, rsp_data.id};
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tlast = rsp_data.last;

endmodule

/* src/scd_checker.sv */
// port-level checks on the scheduler result channel, bound to the top level
module scd_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // only dispatches can be followed by more results of the same command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != scd_pkg::KIND_DISPATCH) |-> rsp_tlast)
      else $error("non-dispatch result without last");

   // a dispatched job always carries a real id and no query flag
   a_dispatch_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == scd_pkg::KIND_DISPATCH) |->
      (rsp_tdata[31:0] != 32'd0) && !rsp_tdata[161])
      else $error("dispatch with zero id");

   // dispatch-only fields stay zero elsewhere
   a_dispatch_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != scd_pkg::KIND_DISPATCH) |->
      (rsp_tdata[160:32] == '0))
      else $error("dispatch fields set on other result");

endmodule

bind job_dependency_scheduler scd_checker u_scd_checker (.*);

/* tb/sv/scd_checker.sv */
// checker: watches the request and result streams and predicts the scheduler's answers
module scd_tb_checker #(
   parameter int JOB_SLOTS = 16,
   parameter int MAX_DEPS  = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [239:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [167:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_wdata,
   output int           fail_count,
   output int           pending_results,
   output int           results_seen,
   output int           dispatches_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPS = (MAX_DEPS < 4) ? MAX_DEPS : 4;

   typedef struct packed {
      logic [2:0]   kind;
      logic [31:0]  id;
      logic [63:0]  timeline;
      logic [63:0]  handle;
      logic         wait_flag;
      logic         done;
      logic         last;
   } answer_type;

   logic         enabled_q;
   logic         active [JOB_SLOTS];
   logic [1:0]   status [JOB_SLOTS];
   logic [31:0]  job_id [JOB_SLOTS];
   logic [63:0]  handle [JOB_SLOTS];
   logic         waitg  [JOB_SLOTS];
   int           ndeps  [JOB_SLOTS];
   logic [31:0]  deps   [JOB_SLOTS][MAX_DEPS];
   logic [31:0]  id_counter;
   logic [63:0]  tl_counter;
   answer_type   answer_queue [$];

   function automatic int slot_of(logic [31:0] id);
      for (int i = 0; i < JOB_SLOTS; i++)
         if (active[i] && job_id[i] == id) return i;
      return -1;
   endfunction

   function automatic bit is_finished(logic [31:0] id);
      int s;
      if (id == 0) return 1;
      s = slot_of(id);
      if (s < 0) return 1;
      return status[s] == scd_pkg::ST_COMPLETED || status[s] == scd_pkg::ST_FAILED;
   endfunction

   function automatic answer_type mk(logic [2:0] k, logic [31:0] id);
      answer_type a;
      a = '0;
      a.kind = k;
      a.id = id;
      return a;
   endfunction

   task automatic predict(input logic [1:0] op, input logic [239:0] d);
      logic [31:0] target;
      logic [7:0]  cnt;
      answer_type  a;
      int          s, n;
      bit          met, named;
      target = d[31:0];
      case (op)
         scd_pkg::OP_SUBMIT: begin
            s = -1;
            if (enabled_q)
               for (int i = 0; i < JOB_SLOTS; i++)
                  if (!active[i]) begin
                     s = i;
                     break;
                  end
            a = mk(scd_pkg::KIND_SUBMIT, 32'd0);
            if (s >= 0) begin
               cnt = d[105:98];
               if (cnt > 8'(DEPS)) cnt = 8'(DEPS);
               a.id = id_counter;
               id_counter++;
               if (id_counter == 0) id_counter = 1;
               active[s] = 1;
               status[s] = scd_pkg::ST_PENDING;
               job_id[s] = a.id;
               handle[s] = d[96:33];
               waitg[s]  = d[97];
               ndeps[s]  = cnt;
               for (int i = 0; i < cnt; i++) deps[s][i] = d[106 + 32*i +: 32];
            end
            answer_queue.push_back(a);
         end
         scd_pkg::OP_EVENT: begin
            s = slot_of(target);
            if (s >= 0 && status[s] == scd_pkg::ST_SUBMITTED)
               status[s] = d[32] ? scd_pkg::ST_FAILED : scd_pkg::ST_COMPLETED;
            answer_queue.push_back(mk(scd_pkg::KIND_ACK, target));
         end
         scd_pkg::OP_UPDATE: begin
            n = 0;
            for (int i = 0; i < JOB_SLOTS; i++) begin
               if (!active[i] || status[i] != scd_pkg::ST_PENDING) continue;
               met = 1;
               for (int k = 0; k < ndeps[i]; k++)
                  if (!is_finished(deps[i][k])) begin
                     met = 0;
                     break;
                  end
               if (!met) continue;
               tl_counter++;
               status[i] = scd_pkg::ST_SUBMITTED;
               a = mk(scd_pkg::KIND_DISPATCH, job_id[i]);
               a.timeline = tl_counter;
               a.handle = handle[i];
               a.wait_flag = waitg[i];
               answer_queue.push_back(a);
               n++;
            end
            for (int i = 0; i < JOB_SLOTS; i++) begin
               if (!active[i] || (status[i] != scd_pkg::ST_COMPLETED &&
                                  status[i] != scd_pkg::ST_FAILED))
                  continue;
               named = 0;
               for (int j = 0; j < JOB_SLOTS; j++) begin
                  if (!active[j] || status[j] != scd_pkg::ST_PENDING) continue;
                  for (int k = 0; k < ndeps[j]; k++)
                     if (deps[j][k] == job_id[i]) named = 1;
               end
               if (!named) active[i] = 0;
            end
            if (n == 0) answer_queue.push_back(mk(scd_pkg::KIND_IDLE, 32'd0));
         end
         default: begin
            a = mk(scd_pkg::KIND_QUERY, target);
            a.done = is_finished(target);
            answer_queue.push_back(a);
         end
      endcase
      answer_queue[answer_queue.size() - 1].last = 1;
   endtask

   task automatic compare(input answer_type got);
      answer_type want;
      if (answer_queue.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected result transaction: kind %0d id %0h", got.kind, got.id);
         return;
      end
      want = answer_queue.pop_front();
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"result mismatch: expected kind %0d id %h tl %h h %h w %b d %b l %b,",
                      " got kind %0d id %h tl %h h %h w %b d %b l %b"},
               want.kind, want.id, want.timeline, want.handle, want.wait_flag, want.done,
               want.last, got.kind, got.id, got.timeline, got.handle, got.wait_flag,
               got.done, got.last);
      end
   endtask

   always @(posedge clock) begin
      answer_type got;
      if (reset) begin
         enabled_q <= 1;
         id_counter = 1;
         tl_counter = 0;
         for (int i = 0; i < JOB_SLOTS; i++) active[i] = 0;
         answer_queue.delete();
         fail_count = 0;
         results_seen <= 0;
         dispatches_seen <= 0;
      end else begin
         // results come out after the request that caused them, so check first
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.id = rsp_tdata[31:0];
            got.timeline = rsp_tdata[95:32];
            got.handle = rsp_tdata[159:96];
            got.wait_flag = rsp_tdata[160];
            got.done = rsp_tdata[161];
            got.last = rsp_tlast;
            compare(got);
            results_seen <= results_seen + 1;
            if (got.kind == scd_pkg::KIND_DISPATCH) dispatches_seen <= dispatches_seen + 1;
         end
         if (req_tvalid && req_tready) predict(req_tuser, req_tdata);
         if (csr_we) enabled_q <= csr_wdata;
      end
      pending_results <= answer_queue.size();
   end
endmodule

/* tb/sv/testbench.sv */
// top of the scheduler testbench: clock, reset, stimulus and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [239:0] req_tdata = '0;
   logic [1:0]   req_tuser = scd_pkg::OP_SUBMIT;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [167:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic         csr_wdata = 0;
   int           fail_count, pending_results, results_seen, dispatches_seen;

   // sink behavior: 0 random stalls, 1 always ready, 2 long hold-off
   int           sink_mode = 0;
   bit           quiet = 0;      // no idling on either side
   int           sent = 0;
   logic [31:0]  recent_ids [$]; // ids handed out, to aim events, queries and deps
   logic [31:0]  guess_id = 1;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   job_dependency_scheduler dut (.*);

   scd_tb_checker chk (.*);

   // result side: random stall bursts, a long hold-off when asked
   always @(posedge clock) begin
      int n;
      if (reset) rsp_tready <= 0;
      else if (sink_mode == 2) begin
         rsp_tready <= 0;
         for (n = 0; n < 400; n++) @(posedge clock);
         sink_mode = 0;
      end else if (quiet || sink_mode == 1 || $urandom_range(0, 3) != 0) rsp_tready <= 1;
      else begin
         rsp_tready <= 0;
         n = $urandom_range(1, 12);
         repeat (n - 1) @(posedge clock);
      end
   end

   // pick an id likely to exist, sometimes zero or anything
   function automatic logic [31:0] pick_id();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'd0;
      if (r == 1) return $urandom;
      if (recent_ids.size() == 0 || r == 2) return guess_id;
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
   endfunction

   task automatic send(input scd_pkg::opcode_type op, input logic [239:0] d);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (op == scd_pkg::OP_SUBMIT) begin
         recent_ids.push_back(guess_id);
         if (recent_ids.size() > 24) void'(recent_ids.pop_front());
         guess_id++;
         if (guess_id == 0) guess_id = 1;
      end
   endtask

   function automatic logic [239:0] pack_cmd(logic [31:0] target, logic failed,
         logic [63:0] hnd, logic wt, logic [7:0] cnt, logic [3:0][31:0] deps);
      return {6'b0, deps, cnt, wt, hnd, failed, target};
   endfunction

   task automatic random_cmd();
      int r;
      logic [3:0][31:0] deps;
      logic [7:0] cnt;
      r = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) deps[i] = pick_id();
      cnt = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      if (r < 4)
         send(scd_pkg::OP_SUBMIT, pack_cmd($urandom, 1'($urandom), {$urandom, $urandom},
              1'($urandom), cnt, deps));
      else if (r < 6)
         send(scd_pkg::OP_EVENT, pack_cmd(pick_id(), 1'($urandom), {$urandom, $urandom},
              1'($urandom), cnt, deps));
      else if (r < 8)
         send(scd_pkg::OP_UPDATE, pack_cmd($urandom, 1'($urandom), {$urandom, $urandom},
              1'($urandom), cnt, deps));
      else
         send(scd_pkg::OP_QUERY, pack_cmd(pick_id(), 1'($urandom), {$urandom, $urandom},
              1'($urandom), cnt, deps));
   endtask

   // let the block drain before touching the enable register
   task automatic drain_and_write(input logic value);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      logic [3:0][31:0] deps;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: chain of jobs, self dependency, extremes, wide dep count
      deps = '{32'd0, 32'd0, 32'd1, 32'd0};
      send(scd_pkg::OP_QUERY, pack_cmd(32'd0, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_SUBMIT, pack_cmd(32'd0, 1'b0, '1, 1'b1, 8'd0, '0));
      send(scd_pkg::OP_SUBMIT, pack_cmd(32'd0, 1'b0, 64'h0, 1'b0, 8'd1,
           {32'd0, 32'd0, 32'd0, 32'd1}));
      send(scd_pkg::OP_SUBMIT, pack_cmd(32'd0, 1'b0, 64'hA5, 1'b0, 8'hFF,
           {32'hFFFF_FFFF, 32'd3, 32'd2, 32'd1}));
      send(scd_pkg::OP_QUERY, pack_cmd(32'd2, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_UPDATE, '0);
      send(scd_pkg::OP_QUERY, pack_cmd(32'd1, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_EVENT, pack_cmd(32'd1, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_EVENT, pack_cmd(32'hFFFF_FFFF, 1'b1, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_UPDATE, '0);
      send(scd_pkg::OP_EVENT, pack_cmd(32'd2, 1'b1, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_UPDATE, '0);
      send(scd_pkg::OP_UPDATE, '0);
      send(scd_pkg::OP_QUERY, pack_cmd(32'd3, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      send(scd_pkg::OP_QUERY, pack_cmd(32'hFFFF_FFFF, 1'b0, 64'd0, 1'b0, 8'd0, '0));
      // table full: more submits than slots
      for (int i = 0; i < 18; i++)
         send(scd_pkg::OP_SUBMIT, pack_cmd(32'd0, 1'b0, {$urandom, $urandom}, i[0],
              8'($urandom_range(0, 4)), deps));

      drain_and_write(1'b0);
      send(scd_pkg::OP_SUBMIT, pack_cmd(32'd0, 1'b0, 64'd1, 1'b1, 8'd2, '1));
      send(scd_pkg::OP_UPDATE, '0);
      drain_and_write(1'b1);

      // long result hold-off while requests keep coming
      sink_mode = 2;
      for (int i = 0; i < 40; i++) random_cmd();

      // sender pauses until everything has come back
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);

      for (int i = 0; i < 30; i++) random_cmd();
      drain_and_write(1'b0);
      for (int i = 0; i < 6; i++) random_cmd();
      drain_and_write(1'b1);
      quiet = 1;
      for (int i = 0; i < 40; i++) random_cmd();
      req_tvalid <= 0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d request transactions, %0d result transactions, %0d dispatches",
               sent, results_seen, dispatches_seen);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

/* sim.f */
src/scd_pkg.sv
src/scd_front.sv
src/scd_engine.sv
src/job_dependency_scheduler.sv
src/scd_checker.sv
tb/sv/scd_checker.sv
tb/sv/testbench.sv
